// ===== hw/rtl/dou_pkg.sv =====
package dou_pkg;

	// Calendar constants for a year without leap days.
	localparam int unsigned DAYS_PER_YEAR = 365;
	localparam int unsigned MONTHS_PER_YEAR = 12;

	// Residues used to fold a 32-bit offset down toward its value modulo 365.
	// 2^16 mod 365 is 201 and 2^32 mod 365 is 251.
	localparam int unsigned FOLD16_RES = 201;
	localparam int unsigned WRAP32_RES = 251;
	localparam int unsigned NEG_ADJUST = DAYS_PER_YEAR - WRAP32_RES;

	// Reciprocal of 365 scaled by 2^25, rounded up.
	localparam int unsigned RECIP_SHIFT = 25;
	localparam int unsigned RECIP_365 = 91930;

	// Start date data handed from the date checker to the date splitter.
	typedef struct packed {
		logic       bad;
		logic [8:0] doy0;
	} date_info_t;

	// Number of days in a month, for months 1 to 12; zero otherwise.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2: len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// Days that come before the first of a month, for months 1 to 12.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] start;
		case (m)
			4'd1: start = 9'd0;
			4'd2: start = 9'd31;
			4'd3: start = 9'd59;
			4'd4: start = 9'd90;
			4'd5: start = 9'd120;
			4'd6: start = 9'd151;
			4'd7: start = 9'd181;
			4'd8: start = 9'd212;
			4'd9: start = 9'd243;
			4'd10: start = 9'd273;
			4'd11: start = 9'd304;
			4'd12: start = 9'd334;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

endpackage

// ===== hw/rtl/dou_offset_reduce.sv =====
module dou_offset_reduce (
	input  logic        clk,
	input  logic [31:0] offset_days,
	output logic [8:0]  omod_s4
);

	logic [23:0] r1_s1;
	logic        neg_s1;
	logic [16:0] r2;
	logic [16:0] r3;
	logic [16:0] r3_s2;
	logic        neg_s2;
	logic [33:0] prod;
	logic [7:0]  q_s3;
	logic [16:0] r3_s3;
	logic        neg_s3;
	logic [16:0] rem_full;
	logic [9:0]  rem;
	logic [8:0]  rem_c;
	logic [9:0]  adj;
	logic [8:0]  omod;

	// Stage 1: fold the upper half of the offset onto the lower half.
	always_ff @(posedge clk) begin
		r1_s1 <= 24'(offset_days[31:16]) * 24'(dou_pkg::FOLD16_RES)
			+ 24'(offset_days[15:0]);
		neg_s1 <= offset_days[31];
	end

	// Stage 2: two more folds bring the value below 2^16 plus a small residue.
	always_comb begin
		r2 = 17'(r1_s1[23:16]) * 17'(dou_pkg::FOLD16_RES) + 17'(r1_s1[15:0]);
		r3 = 17'(r2[16]) * 17'(dou_pkg::FOLD16_RES) + 17'(r2[15:0]);
	end

	always_ff @(posedge clk) begin
		r3_s2 <= r3;
		neg_s2 <= neg_s1;
	end

	// Stage 3: estimate the quotient by 365 with a scaled reciprocal.
	assign prod = 34'(r3_s2) * 34'(dou_pkg::RECIP_365);

	always_ff @(posedge clk) begin
		q_s3 <= prod[dou_pkg::RECIP_SHIFT +: 8];
		r3_s3 <= r3_s2;
		neg_s3 <= neg_s2;
	end

	// Stage 4: form the remainder, correct it once, then account for the sign.
	// A negative offset adds -2^32, which is 114 modulo 365.
	always_comb begin
		rem_full = r3_s3 - 17'(q_s3) * 17'(dou_pkg::DAYS_PER_YEAR);
		rem = rem_full[9:0];
		if (rem >= 10'(dou_pkg::DAYS_PER_YEAR)) begin
			rem_c = 9'(rem - 10'(dou_pkg::DAYS_PER_YEAR));
		end else begin
			rem_c = rem[8:0];
		end
		adj = 10'(rem_c) + (neg_s3 ? 10'(dou_pkg::NEG_ADJUST) : 10'd0);
		if (adj >= 10'(dou_pkg::DAYS_PER_YEAR)) begin
			omod = 9'(adj - 10'(dou_pkg::DAYS_PER_YEAR));
		end else begin
			omod = adj[8:0];
		end
	end

	always_ff @(posedge clk) begin
		omod_s4 <= omod;
	end

endmodule

// ===== hw/rtl/dou_date_check.sv =====
module dou_date_check (
	input  logic               clk,
	input  logic [3:0]         month_in,
	input  logic [4:0]         day_in,
	output dou_pkg::date_info_t info_s4
);

	dou_pkg::date_info_t info;
	dou_pkg::date_info_t info_s1;
	dou_pkg::date_info_t info_s2;
	dou_pkg::date_info_t info_s3;

	// Check the start date and turn it into a zero-based day of year.
	always_comb begin
		info.bad = !(month_in inside {[4'd1:4'd12]}) || (day_in == 5'd0)
			|| (day_in > dou_pkg::month_len(month_in));
		info.doy0 = dou_pkg::month_start(month_in) + 9'(day_in) - 9'd1;
	end

	// Hold the date alongside the offset reduction until stage 4.
	always_ff @(posedge clk) begin
		info_s1 <= info;
		info_s2 <= info_s1;
		info_s3 <= info_s2;
		info_s4 <= info_s3;
	end

endmodule

// ===== hw/rtl/dou_date_split.sv =====
module dou_date_split (
	input  logic               clk,
	input  dou_pkg::date_info_t info_s4,
	input  logic [8:0]         omod_s4,
	output logic               bad_s6,
	output logic [3:0]         month_s6,
	output logic [4:0]         day_s6,
	output logic [8:0]         yday_s6
);

	logic [9:0] pos;
	logic [8:0] doy;
	logic [8:0] doy_s5;
	logic       bad_s5;
	logic [3:0] cnt;
	logic [3:0] m;

	// Stage 5: add the reduced offset and wrap into the year.
	always_comb begin
		pos = 10'(info_s4.doy0) + 10'(omod_s4);
		if (pos >= 10'(dou_pkg::DAYS_PER_YEAR)) begin
			doy = 9'(pos - 10'(dou_pkg::DAYS_PER_YEAR));
		end else begin
			doy = pos[8:0];
		end
	end

	always_ff @(posedge clk) begin
		doy_s5 <= doy;
		bad_s5 <= info_s4.bad;
	end

	// Stage 6: count the month starts at or below the day to find the month.
	always_comb begin
		cnt = 4'd0;
		for (int i = 2; i <= 12; i++) begin
			if (doy_s5 >= dou_pkg::month_start(4'(i))) begin
				cnt = cnt + 4'd1;
			end
		end
		m = cnt + 4'd1;
	end

	// An invalid start date clears every result field.
	always_ff @(posedge clk) begin
		bad_s6 <= bad_s5;
		if (bad_s5) begin
			month_s6 <= 4'd0;
			day_s6 <= 5'd0;
			yday_s6 <= 9'd0;
		end else begin
			month_s6 <= m;
			day_s6 <= 5'(doy_s5 - dou_pkg::month_start(m) + 9'd1);
			yday_s6 <= doy_s5 + 9'd1;
		end
	end

endmodule

// ===== hw/rtl/date_offset_unit.sv =====
// Each item taken on start yields one result on done, in the order the items were taken.
// Throughput: one item per cycle; busy stays low, so start is taken every cycle.
// Six register stages: four fold, reciprocal and remainder steps reduce the offset
// modulo 365, then one wrap step and one month lookup step.
// Reset clears the stage valid bits only; data registers are not reset.
// The receiver cannot stall, and each result is shown for exactly one cycle.
module date_offset_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  month_in,
	input  logic [4:0]  day_in,
	input  logic [31:0] offset_days,
	output logic        done,
	output logic        bad_date,
	output logic [3:0]  month_out,
	output logic [4:0]  day_out,
	output logic [8:0]  year_day_out
);

	dou_pkg::date_info_t info_s4;
	logic [8:0]          omod_s4;
	logic                v_s1;
	logic                v_s2;
	logic                v_s3;
	logic                v_s4;
	logic                v_s5;
	logic                v_s6;

	// The pipeline never backs up, so an item is taken whenever start is high.
	assign busy = 1'b0;

	// Valid bits travel down the pipeline with the items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	dou_offset_reduce u_reduce (
		.clk         (clk),
		.offset_days (offset_days),
		.omod_s4     (omod_s4)
	);

	dou_date_check u_check (
		.clk      (clk),
		.month_in (month_in),
		.day_in   (day_in),
		.info_s4  (info_s4)
	);

	dou_date_split u_split (
		.clk      (clk),
		.info_s4  (info_s4),
		.omod_s4  (omod_s4),
		.bad_s6   (bad_date),
		.month_s6 (month_out),
		.day_s6   (day_out),
		.yday_s6  (year_day_out)
	);

	assign done = v_s6;

`ifndef SYNTH
	// Every item taken yields a result on done, and every result comes from an item taken.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("item taken without a result six cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without a matching item");

	// A bad start date clears all result fields.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && bad_date |-> month_out == 4'd0 && day_out == 5'd0
			&& year_day_out == 9'd0)
		else $error("bad date with nonzero result fields");

	// A good result is a real date whose day of year is in range.
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !bad_date |-> month_out >= 4'd1 && month_out <= 4'd12
			&& day_out >= 5'd1 && day_out <= dou_pkg::month_len(month_out)
			&& year_day_out >= 9'd1 && year_day_out <= 9'd365)
		else $error("result date out of range");
`endif

endmodule

// ===== verif/date_offset_unit_test.sv =====
module date_offset_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without an accepted item or a result before the run is abandoned.
	localparam int STALL_LIMIT = 1000;
	// Cycles to watch for stray results once everything has drained.
	localparam int TAIL_CYCLES = 12;
	localparam int RANDOM_ITEMS = 1000;

	// One start date and its offset, as driven on the input ports.
	typedef struct {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [31:0] offset;
	} date_item_t;

	// The shifted date that one item should produce.
	typedef struct {
		logic       bad;
		logic [3:0] month;
		logic [4:0] day;
		logic [8:0] year_day;
	} shifted_date_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [3:0]  month_in = '0;
	logic [4:0]  day_in = '0;
	logic [31:0] offset_days = '0;
	logic        done;
	logic        bad_date;
	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [8:0]  year_day_out;

	date_item_t    pending_dates[$];
	shifted_date_t shifted_dates[$];

	logic       item_taken = 1'b0;
	int         idle_left = 0;
	int         steady_left = 0;
	int         stall_cycles = 0;
	int         failures = 0;
	date_item_t next_date;

	date_offset_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.month_in     (month_in),
		.day_in       (day_in),
		.offset_days  (offset_days),
		.done         (done),
		.bad_date     (bad_date),
		.month_out    (month_out),
		.day_out      (day_out),
		.year_day_out (year_day_out)
	);

	always #5 clk = ~clk;

	// Length of a month in a year without leap days; zero for a bad month.
	function automatic int month_days(input int m);
		if (m == 2) begin
			return 28;
		end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
			return 30;
		end else if (m >= 1 && m <= int'(dou_pkg::MONTHS_PER_YEAR)) begin
			return 31;
		end
		return 0;
	endfunction

	// Number of days in the year that come before the first of month m.
	function automatic int days_before(input int m);
		int total;
		total = 0;
		for (int k = 1; k < m; k++) begin
			total += month_days(k);
		end
		return total;
	endfunction

	// Shifts a date by a signed offset, wrapping around the 365-day year.
	function automatic shifted_date_t shift_date(input logic [3:0] m, input logic [4:0] d,
		input logic [31:0] off);
		shifted_date_t r;
		longint pos;
		int doy;
		int mon;
		r = '{bad: 1'b0, month: '0, day: '0, year_day: '0};
		if (m < 1 || m > dou_pkg::MONTHS_PER_YEAR || d < 1 || d > month_days(m)) begin
			r.bad = 1'b1;
			return r;
		end
		pos = longint'(days_before(m)) + longint'(d) - 1 + longint'($signed(off));
		// The modulus is kept signed so that a negative position stays negative.
		pos = pos % longint'(dou_pkg::DAYS_PER_YEAR);
		if (pos < 0) begin
			pos += longint'(dou_pkg::DAYS_PER_YEAR);
		end
		doy = int'(pos);
		mon = 1;
		while (mon < int'(dou_pkg::MONTHS_PER_YEAR) && days_before(mon + 1) <= doy) begin
			mon++;
		end
		r.month = mon[3:0];
		r.day = 5'(doy - days_before(mon) + 1);
		r.year_day = 9'(doy + 1);
		return r;
	endfunction

	task automatic add_date(input logic [3:0] m, input logic [4:0] d, input logic [31:0] off);
		pending_dates.push_back('{month: m, day: d, offset: off});
	endtask

	// Driver: presents the next item at the falling edge and holds it until taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !item_taken) begin
			// The current item has not been taken yet; keep it on the ports.
		end else if (idle_left > 0) begin
			start <= 1'b0;
			idle_left <= idle_left - 1;
		end else if (pending_dates.size() > 0) begin
			next_date = pending_dates.pop_front();
			month_in <= next_date.month;
			day_in <= next_date.day;
			offset_days <= next_date.offset;
			start <= 1'b1;
			// Mostly short gaps, a few long ones, and now and then a run with none.
			if (steady_left > 0) begin
				steady_left <= steady_left - 1;
				idle_left <= 0;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:2]: begin
						steady_left <= $urandom_range(20, 60);
						idle_left <= 0;
					end
					[3:44]: idle_left <= 0;
					[45:89]: idle_left <= $urandom_range(1, 3);
					default: idle_left <= $urandom_range(8, 40);
				endcase
			end
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: records accepted items and checks each result against the oldest
	// shifted date still waiting.
	always @(posedge clk) begin
		shifted_date_t want;
		if (arst_n) begin
			item_taken <= start && !busy;
			if (start && !busy) begin
				shifted_dates.push_back(shift_date(month_in, day_in, offset_days));
			end
			if (done === 1'b1) begin
				if (shifted_dates.size() == 0) begin
					$error("result with no item outstanding: bad_date %0d month %0d day %0d",
						bad_date, month_out, day_out);
					failures++;
				end else begin
					want = shifted_dates.pop_front();
					if (bad_date !== want.bad) begin
						$error("bad_date: expected %0d, got %0d", want.bad, bad_date);
						failures++;
					end
					if (month_out !== want.month) begin
						$error("month_out: expected %0d, got %0d", want.month, month_out);
						failures++;
					end
					if (day_out !== want.day) begin
						$error("day_out: expected %0d, got %0d", want.day, day_out);
						failures++;
					end
					if (year_day_out !== want.year_day) begin
						$error("year_day_out: expected %0d, got %0d", want.year_day,
							year_day_out);
						failures++;
					end
				end
			end
			if ((start && !busy) || done === 1'b1) begin
				stall_cycles <= 0;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end else begin
			item_taken <= 1'b0;
		end
	end

	initial begin
		int m;
		int d;
		logic [31:0] off;

		// Directed items: year boundaries, month ends, every kind of bad date
		// and the extreme offsets.
		add_date(1, 1, 0);
		add_date(12, 31, 0);
		add_date(12, 31, 1);
		add_date(1, 1, -1);
		add_date(2, 28, 1);
		add_date(3, 1, -1);
		add_date(2, 29, 0);
		add_date(0, 1, 5);
		add_date(13, 1, 0);
		add_date(15, 31, 32'hFFFF_FFFF);
		add_date(1, 0, 0);
		add_date(4, 31, 0);
		add_date(11, 31, 3);
		add_date(6, 30, 32'h7FFF_FFFF);
		add_date(7, 31, 32'h8000_0000);
		add_date(1, 31, 365);
		add_date(8, 15, -365);
		add_date(9, 30, 730);
		add_date(10, 1, 364);
		add_date(5, 20, 32'hDEAD_BEEF);
		add_date(12, 1, -334);
		add_date(3, 15, 32'h0000_FFFF);
		add_date(12, 31, 32'h8000_0000);
		add_date(1, 1, 32'h7FFF_FFFF);

		// Random items: mostly real dates, the rest any month and day.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 80) begin
				m = $urandom_range(1, dou_pkg::MONTHS_PER_YEAR);
				d = $urandom_range(1, month_days(m));
			end else begin
				m = $urandom_range(0, 15);
				d = $urandom_range(0, 31);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: off = int'($urandom_range(0, 1600)) - 800;
				4, 5: off = $urandom;
				6: begin
					if ($urandom_range(0, 1) == 0) begin
						off = 32'h8000_0000 + $urandom_range(0, 400);
					end else begin
						off = 32'h7FFF_FFFF - $urandom_range(0, 400);
					end
				end
				7: off = (int'($urandom_range(0, 20000)) - 10000)
					* int'(dou_pkg::DAYS_PER_YEAR) + int'($urandom_range(0, 4)) - 2;
				default: off = int'($urandom_range(0, 200000)) - 100000;
			endcase
			add_date(m[3:0], d[4:0], off);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while ((pending_dates.size() > 0 || start || shifted_dates.size() > 0)
			&& stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end

		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
		end else begin
			repeat (TAIL_CYCLES) @(posedge clk);
			if (failures == 0 && shifted_dates.size() == 0) begin
				$display("TB_OK");
			end else begin
				$display("TB_ERROR");
			end
		end
		$finish;
	end

endmodule
